@@ hw/rtl/assert_macros.svh @@
// Assertion wrappers for the RTL. They expand to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising edge, off during reset.
`define DTFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define DTFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define DTFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/dtfp_pkg.sv @@
`default_nettype none

package dtfp_pkg;

	localparam int INT_BITS_DEF    = 31;
	localparam int FRAC_BITS_DEF   = 32;
	localparam int FRAC_DIGITS_DEF = 9;

	localparam int CH_W    = 8;
	localparam int VAL_W   = 64;
	localparam int INT_W   = 31;
	localparam int FRAC9_W = 30;

	localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CH_W-1:0] CH_BS    = 8'd8;
	localparam logic [CH_W-1:0] CH_SO    = 8'd14;
	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

	// fraction digits are kept scaled to nine places
	localparam logic [FRAC9_W-1:0] DIV_C = 30'd1000000000;

	typedef struct packed {
		logic               neg;
		logic [INT_W-1:0]   int_val;
		logic               over;
		logic [FRAC9_W-1:0] frac9;
		logic               bad;
	} rec_t;

	function automatic logic [FRAC9_W-1:0] pow10(input logic [3:0] k);
		logic [FRAC9_W-1:0] r;
		case (k)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			4'd9:    r = 30'd1000000000;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dtfp_parser.sv @@
`default_nettype none

module dtfp_parser #(
	parameter int INT_BITS    = dtfp_pkg::INT_BITS_DEF,
	parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [dtfp_pkg::CH_W-1:0]  ch,
	output logic                       emit,
	output dtfp_pkg::rec_t             rec
);

	localparam int IntW  = dtfp_pkg::INT_W;
	localparam int FracW = dtfp_pkg::FRAC9_W;
	localparam logic [INT_BITS+3:0] IntMax = (INT_BITS+4)'((64'd1 << INT_BITS) - 64'd1);
	localparam logic [3:0] FracLim = 4'(FRAC_DIGITS);

	typedef enum logic [4:0] {
		PH_START   = 5'b00001,
		PH_SIGN    = 5'b00010,
		PH_INT     = 5'b00100,
		PH_FRAC    = 5'b01000,
		PH_DISCARD = 5'b10000
	} phase_t;

	phase_t              phase_q, phase_nxt;
	logic                neg_q, neg_nxt;
	logic [INT_BITS-1:0] acc_q, acc_nxt;
	logic                over_q, over_nxt;
	logic [FracW-1:0]    frac_q, frac_nxt;
	logic [3:0]          cnt_q, cnt_nxt;

	logic                is_space, is_digit, is_sign;
	logic [dtfp_pkg::CH_W-1:0] ch_off;
	logic [3:0]          dig;
	logic [INT_BITS+3:0] acc_t;
	logic [FracW+3:0]    term_full;
	logic [FracW-1:0]    term;

	assign is_space = (ch == dtfp_pkg::CH_SPACE) || (ch > dtfp_pkg::CH_BS && ch < dtfp_pkg::CH_SO);
	assign is_digit = (ch >= dtfp_pkg::CH_ZERO) && (ch <= dtfp_pkg::CH_NINE);
	assign is_sign  = (ch == dtfp_pkg::CH_PLUS) || (ch == dtfp_pkg::CH_MINUS);
	assign ch_off   = ch - dtfp_pkg::CH_ZERO;
	assign dig      = ch_off[3:0];

	// acc * 10 + digit
	assign acc_t = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{INT_BITS{1'b0}}, dig};

	// digit weighted by its place among nine fraction places
	assign term_full = {{FracW{1'b0}}, dig} * {4'b0000, dtfp_pkg::pow10(4'd8 - cnt_q)};
	assign term      = term_full[FracW-1:0];

	always_comb begin
		phase_nxt = phase_q;
		neg_nxt   = neg_q;
		acc_nxt   = acc_q;
		over_nxt  = over_q;
		frac_nxt  = frac_q;
		cnt_nxt   = cnt_q;
		emit      = 1'b0;
		rec       = '0;
		unique case (phase_q) inside
			PH_DISCARD: begin
				if (ch == dtfp_pkg::CH_NUL) begin
					phase_nxt = PH_START;
					neg_nxt   = 1'b0;
					acc_nxt   = '0;
					over_nxt  = 1'b0;
					frac_nxt  = '0;
					cnt_nxt   = '0;
				end
			end
			PH_START, PH_SIGN, PH_INT, PH_FRAC: begin
				if (ch == dtfp_pkg::CH_NUL) begin
					emit         = 1'b1;
					rec.neg      = neg_q;
					rec.int_val  = IntW'(acc_q);
					rec.over     = over_q;
					rec.frac9    = frac_q;
					phase_nxt    = PH_START;
					neg_nxt      = 1'b0;
					acc_nxt      = '0;
					over_nxt     = 1'b0;
					frac_nxt     = '0;
					cnt_nxt      = '0;
				end else if (phase_q == PH_START && is_space) begin
					phase_nxt = PH_START;
				end else if ((phase_q == PH_START || phase_q == PH_SIGN) && is_sign) begin
					if (ch == dtfp_pkg::CH_MINUS) begin
						neg_nxt = !neg_q;
					end
					phase_nxt = PH_SIGN;
				end else if (phase_q != PH_FRAC && ch == dtfp_pkg::CH_DOT) begin
					phase_nxt = PH_FRAC;
				end else if (is_digit) begin
					if (phase_q == PH_FRAC) begin
						// drop digits past the kept places
						if (cnt_q < FracLim) begin
							frac_nxt = frac_q + term;
							cnt_nxt  = cnt_q + 4'd1;
						end
					end else begin
						phase_nxt = PH_INT;
						if (!over_q) begin
							if (acc_t > IntMax) begin
								acc_nxt  = '1;
								over_nxt = 1'b1;
							end else begin
								acc_nxt = acc_t[INT_BITS-1:0];
							end
						end
					end
				end else begin
					emit      = 1'b1;
					rec.bad   = 1'b1;
					phase_nxt = PH_DISCARD;
				end
			end
			default: begin
				phase_nxt = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			over_q  <= 1'b0;
			frac_q  <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			neg_q   <= neg_nxt;
			acc_q   <= acc_nxt;
			over_q  <= over_nxt;
			frac_q  <= frac_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dtfp_conv.sv @@
`default_nettype none

module dtfp_conv #(
	parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  dtfp_pkg::rec_t                     in_rec,
	output logic                               in_ready,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dtfp_pkg::VAL_W-1:0]  value,
	output logic                               bad_char,
	output logic                               int_saturated
);

	localparam int ValW  = dtfp_pkg::VAL_W;
	localparam int FracW = dtfp_pkg::FRAC9_W;
	localparam logic [63:0] RecipFull = (64'd1 << (FRAC_BITS + FracW)) / 64'd1000000000;
	localparam logic [FRAC_BITS:0] Recip = RecipFull[FRAC_BITS:0];
	localparam logic [FracW-1:0] Div = dtfp_pkg::DIV_C;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	dtfp_pkg::rec_t rec_s1, rec_s2, rec_s3;

	logic [FRAC_BITS+FracW:0]   p1;
	logic [FRAC_BITS-1:0]       est_s2, est_s3;
	logic [FRAC_BITS+FracW-1:0] p2, p2_s3;
	logic [FRAC_BITS+FracW-1:0] num, rem;
	logic                       corr;
	logic [FRAC_BITS-1:0]       q;
	logic [ValW-1:0]            mag, mag_s4;
	logic                       neg_s4, bad_s4, over_s4;
	logic [ValW-1:0]            value_s5;
	logic                       bad_s5, over_s5;

	// a stage loads when it is empty or its successor moves
	assign en_s5    = !v_s5 || !out_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// estimate floor(frac9 * 2^F / 1e9) with a truncated reciprocal; low by at most one
	assign p1 = {{(FRAC_BITS+1){1'b0}}, rec_s1.frac9} * {{FracW{1'b0}}, Recip};
	assign p2 = {{FracW{1'b0}}, est_s2} * {{FRAC_BITS{1'b0}}, Div};

	// remainder check fixes the estimate
	assign num  = {rec_s3.frac9, {FRAC_BITS{1'b0}}};
	assign rem  = num - p2_s3;
	assign corr = rem >= {{FRAC_BITS{1'b0}}, Div};
	assign q    = est_s3 + {{(FRAC_BITS-1){1'b0}}, corr};
	assign mag  = (ValW'(rec_s3.int_val) << FRAC_BITS) | ValW'(q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rec_s1 <= in_rec;
		end
		if (en_s2) begin
			rec_s2 <= rec_s1;
			est_s2 <= p1[FracW +: FRAC_BITS];
		end
		if (en_s3) begin
			rec_s3 <= rec_s2;
			est_s3 <= est_s2;
			p2_s3  <= p2;
		end
		if (en_s4) begin
			mag_s4  <= mag;
			neg_s4  <= rec_s3.neg;
			bad_s4  <= rec_s3.bad;
			over_s4 <= rec_s3.over;
		end
		if (en_s5) begin
			value_s5 <= neg_s4 ? ({ValW{1'b0}} - mag_s4) : mag_s4;
			bad_s5   <= bad_s4;
			over_s5  <= over_s4;
		end
	end

	assign out_valid     = v_s5;
	assign value         = value_s5;
	assign bad_char      = bad_s5;
	assign int_saturated = over_s5;

endmodule

`default_nettype wire

@@ hw/rtl/decimal_text_to_fixed_point_core.sv @@
`default_nettype none
`include "assert_macros.svh"

// Parses ASCII decimal text, one byte per beat, into signed fixed point with FRAC_BITS
// fraction bits (Q31.32 by default). A zero byte ends the number and yields one result
// beat; an invalid character yields one result beat with bad_char set, after which
// bytes are dropped up to the next zero byte. The parser takes one byte every cycle,
// including back-to-back numbers, while in_stall is low. Each result goes through a
// five-stage pipeline (reciprocal multiply, back-multiply, remainder fix, sign) that
// holds up to five results, and the input stalls only when that pipeline is full and
// the output is stalled.
module decimal_text_to_fixed_point_core #(
	parameter int INT_BITS    = dtfp_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS   = dtfp_pkg::FRAC_BITS_DEF,
	parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dtfp_pkg::CH_W-1:0]          ch,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dtfp_pkg::VAL_W-1:0]  value,
	output logic                               bad_char,
	output logic                               int_saturated
);

	logic           acc;
	logic           emit;
	logic           ready;
	dtfp_pkg::rec_t rec;

	assign in_stall = !ready;
	assign acc      = in_valid && !in_stall;

	dtfp_parser #(
		.INT_BITS    (INT_BITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (acc),
		.ch     (ch),
		.emit   (emit),
		.rec    (rec)
	);

	dtfp_conv #(
		.FRAC_BITS (FRAC_BITS)
	) u_conv (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (acc && emit),
		.in_rec        (rec),
		.in_ready      (ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.bad_char      (bad_char),
		.int_saturated (int_saturated)
	);

	`DTFP_ASSERT_IMP(a_bad_is_zero, clk, arst_n, out_valid && bad_char, value == '0 && !int_saturated)
	`DTFP_ASSERT_IMP(a_sat_nonzero, clk, arst_n, out_valid && int_saturated, value != '0 && !bad_char)
	`DTFP_ASSERT_IMP(a_empty_no_stall, clk, arst_n, !out_valid, !in_stall)
	`DTFP_ASSERT_NXT(a_one_bad_beat, clk, arst_n, acc && emit && rec.bad, !(emit && rec.bad))

endmodule

`default_nettype wire
